[rtl/wbps_pkg.sv]
// shared types, constants and register codes of the wildcard byte pattern scanner
package wbps_pkg;

  localparam int unsigned MaxPatternBytesDef = 16;
  localparam int unsigned OffsetBitsDef      = 32;
  localparam int unsigned LenW               = 5;
  localparam int unsigned CfgIdxW            = 3;
  localparam int unsigned CfgDataW           = 64;
  localparam int unsigned AddrW              = 64;
  localparam int unsigned CountW             = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PAT_LO   = 3'd0,
    CFG_PAT_HI   = 3'd1,
    CFG_CARE     = 3'd2,
    CFG_LENGTH   = 3'd3,
    CFG_BASE     = 3'd4,
    CFG_FIND_ALL = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       region_last;
  } scan_in_t;

  typedef struct packed {
    logic              match_found;
    logic [31:0]       match_offset;
    logic [AddrW-1:0]  match_address;
    logic [CountW-1:0] match_total;
    logic              region_done;
  } scan_out_t;

  // per-beat control broadcast to every window cell
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

[rtl/wbps_cell.sv]
// one window cell: holds a byte, passes it on, and compares the incoming byte
module wbps_cell import wbps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] pat_i,
  input  logic       care_i,
  input  logic       active_i,
  output logic [7:0] byte_o,
  output logic       hit_o
);

  logic [7:0] byte_q, byte_d;

  // compare on the byte that shifts in this beat
  assign hit_o  = !active_i || !care_i || (byte_i == pat_i);
  assign byte_o = byte_q;

  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.shift) begin
      byte_d = ctrl_i.clear ? 8'h00 : byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'h00;
    end else begin
      byte_q <= byte_d;
    end
  end

endmodule

[rtl/wbps_out_buf.sv]
// two-entry result buffer so input beats keep flowing while a result waits
module wbps_out_buf import wbps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  scan_out_t data_i,
  output logic      full_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output scan_out_t out_data_o
);

  logic      main_vld_q, main_vld_d;
  logic      skid_vld_q, skid_vld_d;
  scan_out_t main_q, main_d;
  scan_out_t skid_q, skid_d;
  logic      pop;

  assign pop         = main_vld_q && !out_stall_i;
  assign full_o      = skid_vld_q;
  assign out_valid_o = main_vld_q;
  assign out_data_o  = main_q;

  always_comb begin
    main_vld_d = main_vld_q;
    skid_vld_d = skid_vld_q;
    main_d     = main_q;
    skid_d     = skid_q;
    if (skid_vld_q) begin
      // no push while the skid entry is taken
      if (pop) begin
        main_d     = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (!main_vld_q || pop) begin
      main_vld_d = push_i;
      if (push_i) begin
        main_d = data_i;
      end
    end else if (push_i) begin
      skid_d     = data_i;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      main_vld_q <= main_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

[rtl/wildcard_byte_pattern_scanner.sv]
// top level of the wildcard byte pattern scanner
// The scanner takes one region byte per clock: the
// byte shifts into a row of MAX_PATTERN_BYTES window cells, every cell compares
// its byte with the pattern byte aligned to it in the same cycle, and the result
// (a match report, the region done marker, or both) lands in a two-entry output
// buffer. Input beats are stalled only when both buffer entries hold results, so
// the sustained rate is one byte per cycle whenever the output side keeps up.
// Pattern byte 0 lines up with the oldest byte of the window; positions whose
// care bit is clear are wildcards. A match is reported only once the region has
// supplied at least pattern_length bytes. Offsets are counted in an
// OFFSET_BITS-wide saturating counter. Configuration writes are always taken
// (ready is tied high) and must happen while no result is outstanding.
module wildcard_byte_pattern_scanner import wbps_pkg::*; #(
  parameter int unsigned MAX_PATTERN_BYTES = MaxPatternBytesDef,
  parameter int unsigned OFFSET_BITS       = OffsetBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  scan_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output scan_out_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // configuration registers
  logic [63:0]      pat_lo_q, pat_hi_q;
  logic [15:0]      care_q;
  logic [LenW-1:0]  len_cfg_q;
  logic [AddrW-1:0] base_q;
  logic             find_all_q;

  // region state
  logic [OFFSET_BITS-1:0] seen_q, seen_d;
  logic                   first_q, first_d;
  logic [CountW-1:0]      cnt_q, cnt_d;

  logic       in_acc;
  logic       buf_full;
  cell_ctrl_t cell_ctrl;
  logic [127:0] pat_all;
  logic [LenW-1:0] len_act;

  logic [7:0] win   [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] cell_hit;

  logic                   seen_sat;
  logic                   enough;
  logic                   hit;
  logic                   report;
  logic                   emit;
  logic [OFFSET_BITS-1:0] offset;
  logic [AddrW-1:0]       offset_ext;
  logic [CountW-1:0]      cnt_new;
  scan_out_t              res;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = buf_full;
  assign in_acc      = in_valid_i && !buf_full;
  assign pat_all     = {pat_hi_q, pat_lo_q};

  // clamp the pattern length to 1..MAX_PATTERN_BYTES
  always_comb begin
    if (len_cfg_q == '0) begin
      len_act = LenW'(1);
    end else if (len_cfg_q > LenW'(MAX_PATTERN_BYTES)) begin
      len_act = LenW'(MAX_PATTERN_BYTES);
    end else begin
      len_act = len_cfg_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q   <= '0;
      pat_hi_q   <= '0;
      care_q     <= 16'hFFFF;
      len_cfg_q  <= LenW'(1);
      base_q     <= '0;
      find_all_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_PAT_LO:   pat_lo_q   <= cfg_data_i;
        CFG_PAT_HI:   pat_hi_q   <= cfg_data_i;
        CFG_CARE:     care_q     <= cfg_data_i[15:0];
        CFG_LENGTH:   len_cfg_q  <= cfg_data_i[LenW-1:0];
        CFG_BASE:     base_q     <= cfg_data_i;
        CFG_FIND_ALL: find_all_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cell_ctrl.shift = in_acc;
  assign cell_ctrl.clear = in_data_i.region_last;

  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
    logic [LenW-1:0] pidx;
    logic [7:0]      byte_in;
    logic            active;

    // window cell k (0 newest) lines up with pattern byte len-1-k
    assign pidx    = len_act - LenW'(k) - LenW'(1);
    assign active  = LenW'(k) < len_act;
    if (k == 0) begin : g_head
      assign byte_in = in_data_i.data_byte;
    end else begin : g_body
      assign byte_in = win[k-1];
    end

    wbps_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (cell_ctrl),
      .byte_i   (byte_in),
      .pat_i    (pat_all[{pidx[3:0], 3'b000} +: 8]),
      .care_i   (care_q[pidx[3:0]]),
      .active_i (active),
      .byte_o   (win[k]),
      .hit_o    (cell_hit[k])
    );
  end

  // seen_q + 1 >= len, written without the increment
  assign seen_sat   = (seen_q == '1);
  assign enough     = seen_sat || (seen_q >= OFFSET_BITS'(len_act - LenW'(1)));
  assign offset     = seen_q - OFFSET_BITS'(seen_sat ? len_act : (len_act - LenW'(1)));
  assign offset_ext = AddrW'(offset);
  assign hit        = enough && (&cell_hit);
  assign report     = hit && (find_all_q || !first_q);
  assign cnt_new    = (report && (cnt_q != '1)) ? (cnt_q + CountW'(1)) : cnt_q;
  assign emit       = in_acc && (report || in_data_i.region_last);

  always_comb begin
    res.match_found   = report;
    res.match_offset  = report ? offset_ext[31:0] : 32'd0;
    res.match_address = report ? (base_q + offset_ext) : '0;
    res.match_total   = cnt_new;
    res.region_done   = in_data_i.region_last;
  end

  always_comb begin
    seen_d  = seen_q;
    first_d = first_q;
    cnt_d   = cnt_q;
    if (in_acc) begin
      if (in_data_i.region_last) begin
        seen_d  = '0;
        first_d = 1'b0;
        cnt_d   = '0;
      end else begin
        seen_d  = seen_sat ? seen_q : (seen_q + OFFSET_BITS'(1));
        first_d = first_q || report;
        cnt_d   = cnt_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      first_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      seen_q  <= seen_d;
      first_q <= first_d;
      cnt_q   <= cnt_d;
    end
  end

  wbps_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (emit),
    .data_i      (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[rtl/wbps_checker.sv]
// port-level checks for the wildcard byte pattern scanner, bound to the top level
module wbps_checker import wbps_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input scan_out_t out_data_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // input is held back only while a result waits
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  // every result is a match, a region end, or both
  a_res_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.match_found || out_data_o.region_done)
    else $error("result beat with neither match nor region end");

  // done-only results carry no position
  a_nomatch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.match_found |->
      (out_data_o.match_offset == 32'd0) && (out_data_o.match_address == '0))
    else $error("done-only result carries a match position");

  // a reported match is counted
  a_match_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.match_found |-> out_data_o.match_total != '0)
    else $error("match reported with zero match total");

endmodule

bind wildcard_byte_pattern_scanner wbps_checker u_wbps_checker (.*);
